// ----- sv/dmq_pkg.sv -----
// Shared types and constants of the delayed message queue.
`timescale 1ns / 1ps
package dmq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] STAT_IMMEDIATE = 2'd0;
  localparam logic [1:0] STAT_RELEASED  = 2'd1;
  localparam logic [1:0] STAT_DUPLICATE = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  localparam logic KIND_DISPATCH = 1'b0;
  localparam logic KIND_TICK     = 1'b1;

  typedef struct packed {
    logic        valid;
    logic [31:0] due;
    logic [15:0] sender;
    logic [15:0] receiver;
    logic [15:0] code;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    entry_t      ent;
    logic [15:0] window;
  } cell_ctl_t;

endpackage

// ----- sv/dmq_cell.sv -----
// One queue slot: holds an entry, inserts in sorted order and shifts toward the head.
`timescale 1ns / 1ps
module dmq_cell import dmq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  entry_t    left_ent,
  input  logic      left_before,
  input  entry_t    right_ent,
  output entry_t    ent,
  output logic      later,
  output logic      hit
);

  entry_t      ent_r;
  logic [31:0] diff;
  logic        same_body;

  assign ent   = ent_r;
  assign later = !ent_r.valid || (ent_r.due > ctl.ent.due);

  assign diff = (ent_r.due > ctl.ent.due) ? (ent_r.due - ctl.ent.due)
                                          : (ctl.ent.due - ent_r.due);
  assign same_body = (ent_r.sender == ctl.ent.sender) &&
                     (ent_r.receiver == ctl.ent.receiver) &&
                     (ent_r.code == ctl.ent.code);
  assign hit = ent_r.valid && same_body && (diff < {16'd0, ctl.window});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      case (ctl.op)
        CELL_INSERT: begin
          if (left_before) begin
            ent_r <= left_ent;
          end else if (later) begin
            ent_r <= ctl.ent;
          end
        end
        CELL_SHIFT: begin
          ent_r <= right_ent;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/delayed_message_queue.sv -----
// Top level of the delayed message queue: control sequencer and chain of slots.
`timescale 1ns / 1ps
// Usage: an input word is taken at a clock edge with start high and busy low.
// in_kind selects a dispatch or a tick. A dispatch with zero delay gives one
// result in the next cycle and leaves busy low. A dispatch with a delay holds
// busy through the due time add, then duplicate/full check and sorted insert
// into the slot chain; a dropped message gives one result at the end of that.
// A tick holds busy and releases the due messages, one per cycle from the head
// of the chain, head first, the final one marked by out_last; their number is
// limited by the slot count and the per-tick release limit.
// Each result word is on the out_ ports for one cycle with out_valid high;
// the receiver cannot stall, so no result is ever held back.
// cfg_we writes the duplicate window from cfg_wdata; write it only while idle.
// Reset (synchronous, rst_n low) empties the queue, sets the window to 1 and
// clears the strobe.
module delayed_message_queue import dmq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [31:0] in_now_time,
  input  logic [23:0] in_delay,
  input  logic [15:0] in_sender,
  input  logic [15:0] in_receiver,
  input  logic [15:0] in_message_code,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output logic [15:0] out_sender,
  output logic [15:0] out_receiver,
  output logic [15:0] out_code,
  output logic [31:0] out_due_time,
  output logic [1:0]  out_status,
  output logic        out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DUE,
    ST_INS,
    ST_REL
  } state_t;

  state_t      state_r;
  logic [15:0] window_r;
  logic [31:0] now_r;
  logic [23:0] delay_r;
  logic [31:0] due_r;
  logic [15:0] sender_r;
  logic [15:0] receiver_r;
  logic [15:0] code_r;
  logic [CNT_W-1:0] rel_cnt_r;

  logic        out_valid_r;
  logic [15:0] out_sender_r;
  logic [15:0] out_receiver_r;
  logic [15:0] out_code_r;
  logic [31:0] out_due_r;
  logic [1:0]  out_status_r;
  logic        out_last_r;

  entry_t    ents [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] before_vec;
  logic [QUEUE_DEPTH-1:0] hit_vec;
  logic [QUEUE_DEPTH-1:0] vld_vec;
  cell_ctl_t ctl;

  logic        accept;
  logic [32:0] due_sum;
  logic        dup;
  logic        full;
  logic        rel;
  logic        next_ok;

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);
  assign due_sum = {1'b0, now_r} + {9'd0, delay_r};
  assign dup     = |hit_vec;
  assign full    = ents[QUEUE_DEPTH-1].valid;
  assign rel     = ents[0].valid && (ents[0].due < now_r) &&
                   (rel_cnt_r < CNT_W'(MAX_RESULTS));
  assign next_ok = ents[1].valid && (ents[1].due < now_r) &&
                   (rel_cnt_r < CNT_W'(MAX_RESULTS - 1));

  always_comb begin
    ctl.window       = window_r;
    ctl.ent.valid    = 1'b1;
    ctl.ent.due      = due_r;
    ctl.ent.sender   = sender_r;
    ctl.ent.receiver = receiver_r;
    ctl.ent.code     = code_r;
    ctl.op           = CELL_HOLD;
    if (state_r == ST_INS && !dup && !full) begin
      ctl.op = CELL_INSERT;
    end else if (state_r == ST_REL && rel) begin
      ctl.op = CELL_SHIFT;
    end
  end

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    entry_t l_ent;
    entry_t r_ent;
    logic   l_bef;
    if (gi == 0) begin : g_head
      assign l_ent = '0;
      assign l_bef = 1'b0;
    end else begin : g_mid
      assign l_ent = ents[gi-1];
      assign l_bef = before_vec[gi-1];
    end
    if (gi == QUEUE_DEPTH - 1) begin : g_tail
      assign r_ent = '0;
    end else begin : g_body
      assign r_ent = ents[gi+1];
    end
    assign vld_vec[gi] = ents[gi].valid;
    dmq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_ent    (l_ent),
      .left_before (l_bef),
      .right_ent   (r_ent),
      .ent         (ents[gi]),
      .later       (before_vec[gi]),
      .hit         (hit_vec[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= 16'd1;
      out_valid_r <= 1'b0;
      rel_cnt_r   <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            now_r      <= in_now_time;
            delay_r    <= in_delay;
            sender_r   <= in_sender;
            receiver_r <= in_receiver;
            code_r     <= in_message_code;
            rel_cnt_r  <= '0;
            if (in_kind == KIND_TICK) begin
              state_r <= ST_REL;
            end else if (in_delay == 24'd0) begin
              out_valid_r    <= 1'b1;
              out_sender_r   <= in_sender;
              out_receiver_r <= in_receiver;
              out_code_r     <= in_message_code;
              out_due_r      <= in_now_time;
              out_status_r   <= STAT_IMMEDIATE;
              out_last_r     <= 1'b1;
            end else begin
              state_r <= ST_DUE;
            end
          end
        end
        ST_DUE: begin
          due_r   <= due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];
          state_r <= ST_INS;
        end
        ST_INS: begin
          if (dup || full) begin
            out_valid_r    <= 1'b1;
            out_sender_r   <= sender_r;
            out_receiver_r <= receiver_r;
            out_code_r     <= code_r;
            out_due_r      <= due_r;
            out_status_r   <= dup ? STAT_DUPLICATE : STAT_FULL;
            out_last_r     <= 1'b1;
          end
          state_r <= ST_IDLE;
        end
        ST_REL: begin
          if (rel) begin
            out_valid_r    <= 1'b1;
            out_sender_r   <= ents[0].sender;
            out_receiver_r <= ents[0].receiver;
            out_code_r     <= ents[0].code;
            out_due_r      <= ents[0].due;
            out_status_r   <= STAT_RELEASED;
            out_last_r     <= !next_ok;
            rel_cnt_r      <= rel_cnt_r + 1'b1;
            if (!next_ok) begin
              state_r <= ST_IDLE;
            end
          end else begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sender   = out_sender_r;
  assign out_receiver = out_receiver_r;
  assign out_code     = out_code_r;
  assign out_due_time = out_due_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;

  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_vec >> 1) & ~vld_vec) == '0)
    else $error("queue slots not packed toward the head");

  a_queued_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_kind == KIND_TICK || in_delay != 24'd0) |=> busy)
    else $error("queued or tick word did not raise busy");

  a_release_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_RELEASED |-> $past(state_r == ST_REL))
    else $error("release result outside a tick");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && out_status == STAT_RELEASED)
    else $error("release burst broken before its final word");

endmodule
